@@ hdl/rce_pkg.sv @@
// ----------------------------------------------------------------------------
// rce_pkg: shared definitions for the Roberts cross edge enhancer
// Widths, limits, register indexes, dimension clamps and the structs that
// carry control between the window, square root and top-level blocks.
// ----------------------------------------------------------------------------
package rce_pkg;

	// Pixel and configuration widths
	localparam int PIX_W = 8;
	localparam int DIM_W = 12;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// Line store depth and column counter width
	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int CMP_W     = (DIM_W > ADDR_W + 1) ? DIM_W : ADDR_W + 1;

	// Row limit and row counter width
	localparam int HEIGHT_LIMIT = 2048;
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

	// Gradient magnitude arithmetic
	localparam int SQ_W    = 2 * PIX_W;     // one squared gradient
	localparam int RAD_W   = SQ_W + 1;      // sum of both squares
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int REM_W   = ROOT_W + 1;    // remainder stays within 2*root
	localparam int CNT_W   = $clog2(ROOT_W + 1);

	// Reset values of the configuration registers
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
	} cfg_t;

	// Control from the sequencer to the window block
	typedef struct packed {
		logic accept;   // input transaction taken this cycle
		logic grad_en;  // line store data valid, form gradients
	} win_ctl_t;

	// Square root request and response
	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	// Effective row width: zero acts as one, larger than the store acts as full
	function automatic logic [CMP_W-1:0] eff_width(input logic [DIM_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (v == '0)
			return CMP_W'(1);
		if (w > CMP_W'(MAX_WIDTH))
			return CMP_W'(MAX_WIDTH);
		return w;
	endfunction

	// Effective frame height with the same clamping
	function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		if (v > DIM_W'(HEIGHT_LIMIT))
			return DIM_W'(HEIGHT_LIMIT);
		return v;
	endfunction

endpackage

@@ hdl/rce_window.sv @@
// ----------------------------------------------------------------------------
// rce_window: line store, raster counters and Roberts gradients
// Tracks column and row, reads the pixel above from the line store, forms
// the two cross differences with zero padding and registers their squares.
// ----------------------------------------------------------------------------
module rce_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rce_pkg::cfg_t               cfg,
	input  rce_pkg::win_ctl_t           ctl,
	input  logic [rce_pkg::PIX_W-1:0]   pixel_in,
	input  logic                        frame_start,
	output logic [rce_pkg::RAD_W-1:0]   sq_sum,
	output logic [rce_pkg::PIX_W-1:0]   pixel
);

	logic [rce_pkg::ADDR_W-1:0] col_q;
	logic [rce_pkg::ROW_W-1:0]  row_q;
	logic [rce_pkg::PIX_W-1:0]  left_q;
	logic [rce_pkg::PIX_W-1:0]  ul_q;

	logic [rce_pkg::PIX_W-1:0]  mem [rce_pkg::MAX_WIDTH];
	logic [rce_pkg::PIX_W-1:0]  rd_q;

	logic [rce_pkg::PIX_W-1:0]  pix_s1;
	logic [rce_pkg::ADDR_W-1:0] col_s1;
	logic [rce_pkg::ROW_W-1:0]  row_s1;
	logic [rce_pkg::SQ_W-1:0]   gx2_s2;
	logic [rce_pkg::SQ_W-1:0]   gy2_s2;

	logic [rce_pkg::CMP_W-1:0]  w_eff;
	logic [rce_pkg::DIM_W-1:0]  h_eff;
	logic [rce_pkg::ADDR_W-1:0] col_pre;
	logic [rce_pkg::ROW_W-1:0]  row_pre;
	logic [rce_pkg::ADDR_W-1:0] col_cur;
	logic [rce_pkg::ROW_W-1:0]  row_cur;
	logic [rce_pkg::DIM_W-1:0]  row_inc;
	logic [rce_pkg::ROW_W-1:0]  row_wrap;
	logic [rce_pkg::CMP_W-1:0]  col_inc;

	logic [rce_pkg::PIX_W-1:0]  up;
	logic [rce_pkg::PIX_W-1:0]  lf;
	logic [rce_pkg::PIX_W-1:0]  ul;
	logic [rce_pkg::PIX_W-1:0]  gx_abs;
	logic [rce_pkg::PIX_W-1:0]  gy_abs;

	// Position of the incoming pixel, wrapping early if the width shrank
	always_comb begin
		w_eff   = rce_pkg::eff_width(cfg.frame_width);
		h_eff   = rce_pkg::eff_height(cfg.frame_height);
		col_pre = frame_start ? '0 : col_q;
		row_pre = frame_start ? '0 : row_q;
		row_inc = rce_pkg::DIM_W'(row_pre) + rce_pkg::DIM_W'(1);
		row_wrap = (row_inc >= h_eff) ? '0 : row_inc[rce_pkg::ROW_W-1:0];
		if (rce_pkg::CMP_W'(col_pre) >= w_eff) begin
			col_cur = '0;
			row_cur = row_wrap;
		end else begin
			col_cur = col_pre;
			row_cur = row_pre;
		end
		col_inc = rce_pkg::CMP_W'(col_cur) + rce_pkg::CMP_W'(1);
	end

	// Row wrap after the pixel, with the row derived from row_cur
	logic [rce_pkg::DIM_W-1:0] row_cur_inc;
	assign row_cur_inc = rce_pkg::DIM_W'(row_cur) + rce_pkg::DIM_W'(1);

	// Raster counters advance when a transaction is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.accept) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_cur_inc >= h_eff) ? '0 : row_cur_inc[rce_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[rce_pkg::ADDR_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Line store: read at accept, write back the pixel in the cycle after
	always_ff @(posedge clk) begin
		if (ctl.accept)
			rd_q <= mem[col_cur];
		if (ctl.grad_en)
			mem[col_s1] <= pix_s1;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			pix_s1 <= pixel_in;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
		end
	end

	// Neighbors with zero padding on first row and first column
	always_comb begin
		up = (row_s1 != '0) ? rd_q : '0;
		if (col_s1 != '0) begin
			lf = left_q;
			ul = (row_s1 != '0) ? ul_q : '0;
		end else begin
			lf = '0;
			ul = '0;
		end
		gx_abs = (ul >= pix_s1) ? ul - pix_s1 : pix_s1 - ul;
		gy_abs = (up >= lf) ? up - lf : lf - up;
	end

	// Neighbor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ul_q   <= '0;
		end else if (ctl.grad_en) begin
			left_q <= pix_s1;
			ul_q   <= up;
		end
	end

	// Squared gradients
	always_ff @(posedge clk) begin
		if (ctl.grad_en) begin
			gx2_s2 <= rce_pkg::SQ_W'(gx_abs) * rce_pkg::SQ_W'(gx_abs);
			gy2_s2 <= rce_pkg::SQ_W'(gy_abs) * rce_pkg::SQ_W'(gy_abs);
		end
	end

	assign sq_sum = rce_pkg::RAD_W'(gx2_s2) + rce_pkg::RAD_W'(gy2_s2);
	assign pixel  = pix_s1;

endmodule

@@ hdl/rce_isqrt.sv @@
// ----------------------------------------------------------------------------
// rce_isqrt: digit-serial integer square root
// Restoring square root: shifts in two radicand bits per cycle and settles
// one root bit per cycle, giving floor(sqrt) once all ROOT_W root bits are settled.
// ----------------------------------------------------------------------------
module rce_isqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rce_pkg::sqrt_req_t    req,
	output rce_pkg::sqrt_rsp_t    rsp
);

	localparam int SH_W = 2 * rce_pkg::ROOT_W;
	localparam int TR_W = rce_pkg::REM_W + 2;

	logic [SH_W-1:0]              rad_q;
	logic [rce_pkg::REM_W-1:0]    rem_q;
	logic [rce_pkg::ROOT_W-1:0]   root_q;
	logic [rce_pkg::CNT_W-1:0]    cnt_q;
	logic                         done_q;

	logic [TR_W-1:0]              rem_sh;
	logic [TR_W-1:0]              trial;
	logic [TR_W-1:0]              diff;

	// One root digit: compare shifted remainder against 4*root + 1
	always_comb begin
		rem_sh = {rem_q, rad_q[SH_W-1 -: 2]};
		trial  = TR_W'({root_q, 2'b01});
		diff   = rem_sh - trial;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= rce_pkg::CNT_W'(rce_pkg::ROOT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - rce_pkg::CNT_W'(1);
			done_q <= (cnt_q == rce_pkg::CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= SH_W'(req.radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[SH_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= diff[rce_pkg::REM_W-1:0];
				root_q <= {root_q[rce_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[rce_pkg::REM_W-1:0];
				root_q <= {root_q[rce_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

	// A new request only arrives once the previous root has settled
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> cnt_q == '0)
		else $error("square root restarted while iterating");

	// Completion follows exactly the last iteration
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0 && $past(cnt_q) == rce_pkg::CNT_W'(1))
		else $error("square root done without finishing iterations");

endmodule

@@ hdl/roberts_cross_edge_enhance.sv @@
// One pixel is processed at a time: in_stall stays high after an input
// transaction until its result is loaded into the output register. The
// digit-serial square root settles one of its 9 root bits per cycle.
// A pending result in the output register does not block the next input.
// Reset (arst_n low, asynchronous) clears counters, neighbor history and
// handshake state; frame_width returns to 640 and frame_height to 480.
// ----------------------------------------------------------------------------
// roberts_cross_edge_enhance: Roberts cross edge detector and enhancer
// Streams raster pixels, forms the 2x2 cross gradients against the line
// store, takes the gradient magnitude and adds it back to the pixel.
// ----------------------------------------------------------------------------
module roberts_cross_edge_enhance (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic [rce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rce_pkg::DIM_W-1:0]         cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rce_pkg::PIX_W-1:0]         pixel_in,
	input  logic                              frame_start,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rce_pkg::PIX_W-1:0]         edge_value,
	output logic [rce_pkg::PIX_W-1:0]         enhanced_value
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_GRAD = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                       state_q;
	rce_pkg::cfg_t                cfg_q;
	rce_pkg::win_ctl_t            win_ctl;
	rce_pkg::sqrt_req_t           sqrt_req;
	rce_pkg::sqrt_rsp_t           sqrt_rsp;
	logic [rce_pkg::RAD_W-1:0]    sq_sum;
	logic [rce_pkg::PIX_W-1:0]    pixel;

	logic                         out_valid_q;
	logic [rce_pkg::PIX_W-1:0]    edge_q;
	logic [rce_pkg::PIX_W-1:0]    enh_q;

	logic                         in_acc;
	logic                         out_free;
	logic [rce_pkg::PIX_W-1:0]    edge_clamp;
	logic [rce_pkg::PIX_W:0]      enh_sum;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= rce_pkg::WIDTH_RESET;
			cfg_q.frame_height <= rce_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				rce_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				rce_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake terms
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_GRAD;
				ST_GRAD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: if (sqrt_rsp.done) state_q <= ST_EMIT;
				ST_EMIT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign win_ctl.accept    = in_acc;
	assign win_ctl.grad_en   = (state_q == ST_GRAD);
	assign sqrt_req.start    = (state_q == ST_SUM);
	assign sqrt_req.radicand = sq_sum;

	rce_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ctl         (win_ctl),
		.pixel_in    (pixel_in),
		.frame_start (frame_start),
		.sq_sum      (sq_sum),
		.pixel       (pixel)
	);

	rce_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// Clamp magnitude and enhanced pixel
	always_comb begin
		edge_clamp = (sqrt_rsp.root > rce_pkg::ROOT_W'(rce_pkg::PIX_MAX)) ?
			rce_pkg::PIX_MAX : sqrt_rsp.root[rce_pkg::PIX_W-1:0];
		enh_sum = {1'b0, pixel} + {1'b0, edge_clamp};
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			edge_q <= edge_clamp;
			enh_q  <= enh_sum[rce_pkg::PIX_W] ? rce_pkg::PIX_MAX : enh_sum[rce_pkg::PIX_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign edge_value     = edge_q;
	assign enhanced_value = enh_q;

	// An accepted pixel always moves on to gradient formation
	a_accept_grad: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_GRAD)
		else $error("accepted transaction did not start gradient stage");

	// A new result is only loaded from the emit state
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result appeared outside emit state");

	// Root completion is only seen while waiting on it
	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_rsp.done |-> state_q == ST_ROOT)
		else $error("square root completed outside root state");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for roberts_cross_edge_enhance
// Streams raster pixels through the block under random idling on both
// channels. An in-bench predictor tracks the line store, neighbors and the
// row/column counters, and each output transaction is compared field by
// field in order. Frame sizes are changed only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CYCLE_LIMIT  = 4000000;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned LONG_RUN     = 96;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned PRINT_LIMIT  = 40;

	typedef enum int unsigned {START_FIRST, START_FRAMES, START_NOISE} start_mode_t;

	typedef struct packed {
		logic [rce_pkg::PIX_W-1:0] pix;
		logic                      start;
	} pixel_item_t;

	typedef struct packed {
		logic [rce_pkg::PIX_W-1:0] mag;
		logic [rce_pkg::PIX_W-1:0] boosted;
	} edge_result_t;

	// DUT ports, all inputs known from time zero
	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_write   = 1'b0;
	logic [rce_pkg::CFG_IDX_W-1:0] cfg_index   = rce_pkg::REG_FRAME_WIDTH;
	logic [rce_pkg::DIM_W-1:0]     cfg_data    = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic [rce_pkg::PIX_W-1:0]     pixel_in    = '0;
	logic                          frame_start = 1'b0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [rce_pkg::PIX_W-1:0]     edge_value;
	logic [rce_pkg::PIX_W-1:0]     enhanced_value;

	// Predictor state
	logic [rce_pkg::PIX_W-1:0] line_mem [rce_pkg::MAX_WIDTH];
	logic [rce_pkg::PIX_W-1:0] left_px      = '0;
	logic [rce_pkg::PIX_W-1:0] upleft_px    = '0;
	int unsigned               model_col    = 0;
	int unsigned               model_row    = 0;
	logic [rce_pkg::DIM_W-1:0] model_width  = rce_pkg::WIDTH_RESET;
	logic [rce_pkg::DIM_W-1:0] model_height = rce_pkg::HEIGHT_RESET;

	// Stimulus and expectation stores
	pixel_item_t  pixel_feed[$];
	edge_result_t edge_results_due[$];

	logic        in_fire     = 1'b0;
	bit          calm        = 1'b0;
	int unsigned tx_gap      = 0;
	int unsigned rx_left     = 0;
	int unsigned plan_width  = 640;
	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;

	wire in_take  = arst_n && in_valid && (in_stall === 1'b0);
	wire out_take = arst_n && (out_valid === 1'b1) && !out_stall;

	roberts_cross_edge_enhance u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_in       (pixel_in),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.edge_value     (edge_value),
		.enhanced_value (enhanced_value)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Zero acts as one, anything past the limit acts as the limit
	function automatic int unsigned clamp_dim(input logic [rce_pkg::DIM_W-1:0] v,
			input int unsigned lim);
		if (v == '0)
			return 1;
		if (32'(v) > lim)
			return lim;
		return 32'(v);
	endfunction

	function automatic void advance_row();
		model_col = 0;
		model_row++;
		if (model_row >= clamp_dim(model_height, rce_pkg::HEIGHT_LIMIT))
			model_row = 0;
	endfunction

	// Roberts cross magnitude and enhanced pixel for one accepted pixel
	function automatic edge_result_t predict_edge_pixel(input logic [rce_pkg::PIX_W-1:0] pix,
			input logic start);
		edge_result_t res;
		int unsigned  w, up, ul, lf, sum, root, total;
		int           gx, gy;
		w = clamp_dim(model_width, rce_pkg::MAX_WIDTH);
		if (start) begin
			model_col = 0;
			model_row = 0;
		end
		if (model_col >= w)
			advance_row();

		// zero padding above the first row and left of the first column
		up = (model_row > 0) ? 32'(line_mem[rce_pkg::ADDR_W'(model_col)]) : 0;
		if (model_col > 0) begin
			lf = 32'(left_px);
			ul = (model_row > 0) ? 32'(upleft_px) : 0;
		end else begin
			lf = 0;
			ul = 0;
		end

		gx = int'(ul) - int'(pix);
		gy = int'(up) - int'(lf);
		sum = unsigned'(gx * gx + gy * gy);
		root = 0;
		while ((root + 1) * (root + 1) <= sum)
			root++;
		if (root > 32'(rce_pkg::PIX_MAX))
			root = 32'(rce_pkg::PIX_MAX);
		total = 32'(pix) + root;
		if (total > 32'(rce_pkg::PIX_MAX))
			total = 32'(rce_pkg::PIX_MAX);

		line_mem[rce_pkg::ADDR_W'(model_col)] = pix;
		left_px = pix;
		upleft_px = up[rce_pkg::PIX_W-1:0];
		model_col++;
		if (model_col >= w)
			advance_row();

		res.mag = root[rce_pkg::PIX_W-1:0];
		res.boosted = total[rce_pkg::PIX_W-1:0];
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(16, 4);
		return $urandom_range(60, 20);
	endfunction

	// Uniform, extreme, or close to the previous pixel
	function automatic logic [rce_pkg::PIX_W-1:0] pick_pixel(
			input logic [rce_pkg::PIX_W-1:0] last);
		int unsigned r;
		int          v;
		r = $urandom_range(99);
		if (r < 55)
			return rce_pkg::PIX_W'($urandom_range(255));
		if (r < 75)
			return $urandom_range(1) ? rce_pkg::PIX_MAX : '0;
		v = int'(last) + int'($urandom_range(16)) - 8;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return rce_pkg::PIX_W'(v);
	endfunction

	task automatic report_mismatch(input string what, input logic [rce_pkg::PIX_W-1:0] got,
			input logic [rce_pkg::PIX_W-1:0] want);
		if (err_count < PRINT_LIMIT)
			$display("mismatch on %s at cycle %0d: got %0d, expected %0d",
				what, cycle_count, got, want);
		err_count++;
	endtask

	task automatic queue_pixel(input logic [rce_pkg::PIX_W-1:0] pix, input logic start);
		pixel_item_t item;
		item.pix = pix;
		item.start = start;
		pixel_feed.push_back(item);
	endtask

	// Wait until every pixel is sent and every result is back
	task automatic drain_pipeline();
		while (pixel_feed.size() != 0 || in_valid || edge_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [rce_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= rce_pkg::DIM_W'(value);
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == rce_pkg::REG_FRAME_WIDTH)
			model_width = rce_pkg::DIM_W'(value);
		else
			model_height = rce_pkg::DIM_W'(value);
	endtask

	// New frame size on an idle block; grow is set when the row got wider,
	// so the caller restarts the frame and never reads an unwritten column
	task automatic set_frame(input int unsigned w_val, input int unsigned h_val,
			output logic grow);
		int unsigned w_eff;
		w_eff = clamp_dim(rce_pkg::DIM_W'(w_val), rce_pkg::MAX_WIDTH);
		grow = (w_eff > plan_width);
		drain_pipeline();
		if ($urandom_range(1)) begin
			write_cfg(rce_pkg::REG_FRAME_WIDTH, w_val);
			write_cfg(rce_pkg::REG_FRAME_HEIGHT, h_val);
		end else begin
			write_cfg(rce_pkg::REG_FRAME_HEIGHT, h_val);
			write_cfg(rce_pkg::REG_FRAME_WIDTH, w_val);
		end
		plan_width = w_eff;
	endtask

	task automatic run_phase(input int unsigned w_val, input int unsigned h_val,
			input int unsigned count, input start_mode_t mode, input bit quiet);
		logic                      grow;
		logic                      st;
		logic [rce_pkg::PIX_W-1:0] p;
		int unsigned               frame_len;
		frame_len = clamp_dim(rce_pkg::DIM_W'(w_val), rce_pkg::MAX_WIDTH)
			* clamp_dim(rce_pkg::DIM_W'(h_val), rce_pkg::HEIGHT_LIMIT);
		set_frame(w_val, h_val, grow);
		calm = quiet;
		p = rce_pkg::PIX_W'($urandom_range(255));
		for (int unsigned i = 0; i < count; i++) begin
			case (mode)
				START_FIRST:  st = (i == 0);
				START_FRAMES: st = (i % frame_len == 0);
				default:      st = ($urandom_range(9) == 0);
			endcase
			if (i == 0 && grow)
				st = 1'b1;
			p = pick_pixel(p);
			queue_pixel(p, st);
		end
	endtask

	// Input driver: hold a stalled transaction, else idle or launch the next pixel
	always @(negedge clk) begin : px_driver
		pixel_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (tx_gap != 0) begin
				tx_gap = tx_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_feed.size() != 0) begin
				item = pixel_feed.pop_front();
				pixel_in    <= item.pix;
				frame_start <= item.start;
				in_valid    <= 1'b1;
				tx_gap = calm ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall: free runs alternate with stalls of random length
	always @(negedge clk) begin : rx_stall
		if (rx_left != 0) begin
			rx_left = rx_left - 1;
		end else if (out_stall || calm) begin
			out_stall <= 1'b0;
			rx_left = $urandom_range(8);
		end else begin
			rx_left = pick_gap();
			out_stall <= (rx_left != 0);
		end
	end

	// Predict on each input transaction, check each output transaction
	always @(posedge clk) begin : scoreboard
		edge_result_t want;
		in_fire <= in_take;
		if (in_take)
			edge_results_due.push_back(predict_edge_pixel(pixel_in, frame_start));
		if (out_take) begin
			if (edge_results_due.size() == 0) begin
				report_mismatch("result with no transaction pending", edge_value, '0);
			end else begin
				want = edge_results_due.pop_front();
				if (edge_value !== want.mag)
					report_mismatch("edge_value", edge_value, want.mag);
				if (enhanced_value !== want.boosted)
					report_mismatch("enhanced_value", enhanced_value, want.boosted);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("roberts_cross_edge_enhance verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic        grow;
		int unsigned w, h, count, fed, r;
		start_mode_t mode;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset dimensions, first pixels after reset
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);

		// 4x2 of alternating extremes: clamped magnitude, then frame wrap
		// without frame_start and a restart in the middle of a row
		set_frame(4, 2, grow);
		queue_pixel(8'd0, 1'b1);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd100, 1'b0);
		queue_pixel(8'd200, 1'b1);

		// 5-wide rows; narrowing to 2 while in column 3 starts a new row
		// on line store data from the row before
		set_frame(5, 4, grow);
		queue_pixel(8'd17, 1'b1);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd128, 1'b0);
		queue_pixel(8'd64, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd30, 1'b0);
		set_frame(2, 4, grow);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd90, 1'b0);

		// Zero width and zero height act as one
		set_frame(0, 0, grow);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd40, 1'b0);

		// Random frame sizes, mostly small; two short runs at the size limits
		fed = 0;
		for (int seg = 0; seg < 2; seg++) begin
			while (fed < (seg + 1) * RANDOM_ITEMS / 2) begin
				r = $urandom_range(99);
				if (r < 50)
					w = $urandom_range(8, 1);
				else if (r < 75)
					w = $urandom_range(40, 9);
				else if (r < 85)
					w = $urandom_range(200, 41);
				else if (r < 92)
					w = 0;
				else
					w = $urandom_range(4095, 2049);
				r = $urandom_range(99);
				if (r < 60)
					h = $urandom_range(6, 1);
				else if (r < 80)
					h = $urandom_range(40, 7);
				else if (r < 88)
					h = 0;
				else
					h = $urandom_range(4095, 2048);
				count = clamp_dim(rce_pkg::DIM_W'(w), rce_pkg::MAX_WIDTH)
					* clamp_dim(rce_pkg::DIM_W'(h), rce_pkg::HEIGHT_LIMIT)
					* $urandom_range(3, 1) + $urandom_range(6);
				if (count < 12)
					count = 12;
				if (count > 160)
					count = 160;
				r = $urandom_range(99);
				mode = (r < 40) ? START_FRAMES : (r < 75) ? START_FIRST : START_NOISE;
				run_phase(w, h, count, mode, $urandom_range(4) == 0);
				fed += count;
			end
			if (seg == 0) begin
				// 4095 acts as the full line store width
				run_phase(4095, 2, LONG_RUN, START_FIRST, 1'b1);
				// 4095 rows act as the row limit
				run_phase(1, 4095, LONG_RUN, START_FIRST, 1'b1);
			end
		end

		drain_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("roberts_cross_edge_enhance verification clean");
		else
			$display("roberts_cross_edge_enhance verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/rce_pkg.sv
hdl/rce_window.sv
hdl/rce_isqrt.sv
hdl/roberts_cross_edge_enhance.sv
bench/tb.sv
